>>> rtl/core/tcsps_pkg.sv
// ----------------------------------------------------------------------------
// tcsps_pkg
// Shared types and constants of the two-class stable priority sorter.
// ----------------------------------------------------------------------------
package tcsps_pkg;

    localparam int PRIO_W    = 16;   // priority and register width
    localparam int KIND_W    = 3;
    localparam int KIDX_W    = 5;    // task_index port width
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_CEIL = 1'd1;

    localparam logic [PRIO_W-1:0] SYS_LIMIT_RST = 16'd50;
    localparam logic [PRIO_W-1:0] USER_CEIL_RST = 16'd255;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SYS      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_USER     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SYS_END  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_USER_END = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KIDX_W-1:0] task_index;
        logic              final_res;
    } t_result;

endpackage

>>> rtl/core/tcsps_order_mem.sv
// ----------------------------------------------------------------------------
// tcsps_order_mem
// Order list store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcsps_order_mem #(
    parameter int AW = 6,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tcsps_ctrl.sv
// ----------------------------------------------------------------------------
// tcsps_ctrl
// Sequencer: classifies each request, walks the order list for the stable
// insertion and flushes both lists on the final request.
// ----------------------------------------------------------------------------
module tcsps_ctrl
    import tcsps_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_accept,
    input  logic [PRIO_W-1:0]                         i_prio,
    input  logic                                      i_last,
    input  logic [PRIO_W-1:0]                         i_sys_limit,
    input  logic [PRIO_W-1:0]                         i_user_ceil,
    input  logic                                      i_out_free,
    output logic                                      o_busy,
    output logic                                      o_res_vld,
    output t_result                                   o_res,
    output logic                                      o_mem_we,
    output logic [$clog2(MAX_TASKS):0]                o_mem_waddr,
    output logic [PRIO_W+$clog2(MAX_TASKS)-1:0]       o_mem_wdata,
    output logic                                      o_mem_re,
    output logic [$clog2(MAX_TASKS):0]                o_mem_raddr,
    input  logic [PRIO_W+$clog2(MAX_TASKS)-1:0]       i_mem_rdata
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = IW + KIDX_W;
    localparam logic [CW-1:0]     MAXC     = CW'(MAX_TASKS);
    localparam logic [KIDX_W-1:0] DROP_IDX = KIDX_W'(MAX_TASKS % (1 << KIDX_W));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RPT  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;
    localparam logic [2:0] S_FRD  = 3'd5;
    localparam logic [2:0] S_FWR  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [PRIO_W-1:0] r_prio,  n_prio;
    logic              r_last,  n_last;
    logic              r_drop,  n_drop;
    logic [IW-1:0]     r_idx,   n_idx;
    logic              r_cls,   n_cls;    // 0 system list, 1 user list
    logic [CW-1:0]     r_pos,   n_pos;
    logic [CW-1:0]     r_arr,   n_arr;
    logic [CW-1:0]     r_cnt_sys, n_cnt_sys;
    logic [CW-1:0]     r_cnt_usr, n_cnt_usr;

    logic [CW-1:0]     pos_m1, pos_m2, cnt_sel, new_cnt, new_cnt_m1;
    logic              new_cls;
    logic [PRIO_W-1:0] rd_prio;
    logic [IW-1:0]     rd_idx;
    logic [XW-1:0]     rd_idx_x, r_idx_x;

    assign pos_m1     = r_pos - CW'(1);
    assign pos_m2     = r_pos - CW'(2);
    assign cnt_sel    = r_cls ? r_cnt_usr : r_cnt_sys;
    assign new_cls    = (r_prio < i_sys_limit) ? 1'b0 : 1'b1;
    assign new_cnt    = new_cls ? r_cnt_usr : r_cnt_sys;
    assign new_cnt_m1 = new_cnt - CW'(1);
    assign rd_prio    = i_mem_rdata[PRIO_W+IW-1:IW];
    assign rd_idx     = i_mem_rdata[IW-1:0];
    assign rd_idx_x   = XW'(rd_idx);
    assign r_idx_x    = XW'(r_idx);

    always_comb begin
        n_state     = r_state;
        n_prio      = r_prio;
        n_last      = r_last;
        n_drop      = r_drop;
        n_idx       = r_idx;
        n_cls       = r_cls;
        n_pos       = r_pos;
        n_arr       = r_arr;
        n_cnt_sys   = r_cnt_sys;
        n_cnt_usr   = r_cnt_usr;
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_cls, r_pos[IW-1:0]};
        o_mem_wdata = {r_prio, r_idx};
        o_mem_re    = 1'b0;
        o_mem_raddr = {r_cls, pos_m1[IW-1:0]};
        o_res_vld   = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_prio  = i_prio;
                    n_last  = i_last;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_arr >= MAXC) begin
                    n_drop = 1'b1;
                    if (r_last) begin
                        // dropped final request: no report, straight to flush
                        n_cls   = 1'b0;
                        n_pos   = '0;
                        n_state = S_FRD;
                    end else begin
                        n_state = S_RPT;
                    end
                end else begin
                    n_idx  = r_arr[IW-1:0];
                    n_arr  = r_arr + CW'(1);
                    n_drop = 1'b0;
                    if (r_prio > i_user_ceil) begin
                        n_state = S_RPT;
                    end else begin
                        n_cls = new_cls;
                        n_pos = new_cnt;
                        if (new_cnt == '0) begin
                            n_state = S_PUT;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = {new_cls, new_cnt_m1[IW-1:0]};
                            n_state     = S_WALK;
                        end
                    end
                end
            end
            S_RPT: begin
                if (i_out_free) begin
                    o_res_vld        = 1'b1;
                    o_res.kind       = r_drop ? KIND_DROPPED : KIND_ILLEGAL;
                    o_res.task_index = r_drop ? DROP_IDX : r_idx_x[KIDX_W-1:0];
                    if (r_last) begin
                        n_cls   = 1'b0;
                        n_pos   = '0;
                        n_state = S_FRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK: begin
                // read data is the entry just above the hole at r_pos
                if (r_prio < rd_prio) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = pos_m1;
                    if (pos_m1 != '0) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = {r_cls, pos_m2[IW-1:0]};
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_mem_we = 1'b1;
                if (r_cls) begin
                    n_cnt_usr = r_cnt_usr + CW'(1);
                end else begin
                    n_cnt_sys = r_cnt_sys + CW'(1);
                end
                if (r_last) begin
                    n_cls   = 1'b0;
                    n_pos   = '0;
                    n_state = S_FRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                if (r_pos < cnt_sel) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = {r_cls, r_pos[IW-1:0]};
                    n_state     = S_FWR;
                end else if (i_out_free) begin
                    o_res_vld       = 1'b1;
                    o_res.kind      = r_cls ? KIND_USER_END : KIND_SYS_END;
                    o_res.final_res = r_cls;
                    if (!r_cls) begin
                        n_cls = 1'b1;
                        n_pos = '0;
                    end else begin
                        n_cnt_sys = '0;
                        n_cnt_usr = '0;
                        n_arr     = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_FWR: begin
                if (i_out_free) begin
                    o_res_vld        = 1'b1;
                    o_res.kind       = r_cls ? KIND_USER : KIND_SYS;
                    o_res.task_index = rd_idx_x[KIDX_W-1:0];
                    n_pos            = r_pos + CW'(1);
                    n_state          = S_FRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_arr     <= '0;
            r_cnt_sys <= '0;
            r_cnt_usr <= '0;
        end else begin
            r_state   <= n_state;
            r_arr     <= n_arr;
            r_cnt_sys <= n_cnt_sys;
            r_cnt_usr <= n_cnt_usr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_last <= n_last;
        r_drop <= n_drop;
        r_idx  <= n_idx;
        r_cls  <= n_cls;
        r_pos  <= n_pos;
    end

    assign o_busy = (r_state != S_IDLE);

    // both lists together never hold more tasks than indices handed out
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt_sys} + {1'b0, r_cnt_usr}) <= {1'b0, r_arr})
        else $error("list lengths exceed arrival count");

    a_res_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (r_state == S_RPT || r_state == S_FRD || r_state == S_FWR))
        else $error("result issued outside a report or flush state");

    // the walk never reads the entry it is writing
    a_mem_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("order store read and write on the same entry");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == S_IDLE) |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated");

endmodule

>>> rtl/core/two_class_stable_priority_sorter.sv
// ----------------------------------------------------------------------------
// two_class_stable_priority_sorter
// Sorts a batch of task priorities into a system list and a user list.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; o_in_stall stays high until a request is
// fully handled. A request passes through evaluation, then the insertion walk
// over the list entries it compares (up to MAX_TASKS - 1), then the put; the
// walk reads and shifts one entry per cycle through the single order store.
// An illegal or dropped request passes from evaluation to a report state that
// issues its report; a dropped final request skips the report. The final
// request then flushes both lists: each listed task is read from the store
// and then issued, and each list ends with an end marker. Results leave
// through an output register, so a stalled consumer only delays the reports
// and the flush.
module two_class_stable_priority_sorter
    import tcsps_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KIND_W-1:0]    o_kind,
    output logic [KIDX_W-1:0]    o_task_index,
    output logic                 o_final_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PRIO_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int AW = IW + 1;
    localparam int DW = PRIO_W + IW;

    logic [PRIO_W-1:0] r_sys_limit;
    logic [PRIO_W-1:0] r_user_ceil;
    logic              r_out_vld;
    t_result           r_out;

    logic              accept;
    logic              busy;
    logic              out_free;
    logic              res_vld;
    t_result           res;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DW-1:0]     mem_wdata, mem_rdata;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign out_free   = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_limit <= SYS_LIMIT_RST;
            r_user_ceil <= USER_CEIL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYS_LIMIT: r_sys_limit <= i_cfg_data;
                CFG_USER_CEIL: r_user_ceil <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_kind       = r_out.kind;
    assign o_task_index = r_out.task_index;
    assign o_final_res  = r_out.final_res;

    tcsps_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_prio      (i_priority_req),
        .i_last      (i_last),
        .i_sys_limit (r_sys_limit),
        .i_user_ceil (r_user_ceil),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcsps_order_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
